// ===== rtl/dominant_channel_color_fade_macros.svh =====
// Assertion macros used by the top level of the colour fade RTL.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef DOMINANT_CHANNEL_COLOR_FADE_MACROS_SVH
`define DOMINANT_CHANNEL_COLOR_FADE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dcf assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define DCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dcf assertion failed");

`endif

// ===== rtl/dcf_pkg.sv =====
// Types, codes and helper functions for the dominant-channel colour fade.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dcf_pkg;

	localparam int OFF_W = 7;

	typedef logic signed [OFF_W-1:0] off_t;

	// One set of the three offsets a, b and c.
	typedef struct packed {
		off_t a;
		off_t b;
		off_t c;
	} off_set_t;

	// Mode register, bit 2 down to bit 0.
	typedef struct packed {
		logic smooth;
		logic randomize;
		logic enable;
	} mode_t;

	typedef struct packed {
		logic       func;
		logic [7:0] chan0_in;
		logic [7:0] chan1_in;
		logic [7:0] chan2_in;
		logic       beat;
		logic [4:0] rand_a;
		logic [5:0] rand_b;
		logic [4:0] rand_c;
	} in_item_t;

	typedef struct packed {
		logic [7:0] chan0_out;
		logic [7:0] chan1_out;
		logic [7:0] chan2_out;
	} out_item_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_BASE_A = 3'd1,
		REG_BASE_B = 3'd2,
		REG_BASE_C = 3'd3,
		REG_BEAT_A = 3'd4,
		REG_BEAT_B = 3'd5,
		REG_BEAT_C = 3'd6
	} cfg_reg_t;

	// Item kinds carried in the func field.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	// Reset values.
	localparam mode_t MODE_RST = '{smooth: 1'b0, randomize: 1'b0, enable: 1'b1};
	localparam off_t  OFF_RST_POS = 7'sd8;
	localparam off_t  OFF_RST_NEG = -7'sd8;
	localparam off_set_t OFF_SET_RST = '{a: OFF_RST_POS, b: OFF_RST_NEG, c: OFF_RST_NEG};

	// Clamp an eight-bit signed value to the range -lim..lim.
	function automatic off_t clamp_off(input logic signed [7:0] v,
		input logic signed [7:0] lim);
		logic signed [7:0] r;
		if (v < -lim) begin
			r = -lim;
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r[OFF_W-1:0];
	endfunction

endpackage

// ===== rtl/dcf_cfg_regs.sv =====
// Configuration registers: mode flags, base offsets and beat offsets.
// Depends on dcf_pkg; raises a resync strobe after every valid write to a listed register.
`timescale 1ns / 1ps

module dcf_cfg_regs import dcf_pkg::*; #(
	parameter int OFFSET_LIMIT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	output mode_t      mode,
	output off_set_t   base,
	output off_set_t   beat_off,
	output logic       resync
);

	localparam logic signed [7:0] LIM = 8'(OFFSET_LIMIT);

	mode_t    mode_q;
	off_set_t base_q;
	off_set_t beat_q;
	logic     resync_q;
	off_t     data_clamped;
	logic     known_index;

	// Offset registers always hold a value within the limit.
	assign data_clamped = clamp_off({cfg_data[6], cfg_data}, LIM);

	// Only a write to one of the listed registers resyncs the current offsets.
	assign known_index = cfg_index <= REG_BEAT_C;

	// Register writes; an unknown index leaves everything untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RST;
			base_q   <= OFF_SET_RST;
			beat_q   <= OFF_SET_RST;
			resync_q <= 1'b0;
		end else begin
			resync_q <= cfg_valid && known_index;
			if (cfg_valid) begin
				case (cfg_index)
					REG_MODE:   mode_q   <= mode_t'(cfg_data[2:0]);
					REG_BASE_A: base_q.a <= data_clamped;
					REG_BASE_B: base_q.b <= data_clamped;
					REG_BASE_C: base_q.c <= data_clamped;
					REG_BEAT_A: beat_q.a <= data_clamped;
					REG_BEAT_B: beat_q.b <= data_clamped;
					REG_BEAT_C: beat_q.c <= data_clamped;
					default:    ;
				endcase
			end
		end
	end

	assign mode     = mode_q;
	assign base     = base_q;
	assign beat_off = beat_q;
	assign resync   = resync_q;

endmodule

// ===== rtl/dcf_offsets.sv =====
// Current offset state: resync after register writes and update on frame start.
// Depends on dcf_pkg; fed by dcf_cfg_regs and the input stage of the top level.
`timescale 1ns / 1ps

module dcf_offsets import dcf_pkg::*; #(
	parameter int OFFSET_LIMIT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mode_t      mode,
	input  off_set_t   base,
	input  off_set_t   beat_off,
	input  logic       resync,
	input  logic       frame_go,
	input  logic       beat,
	input  logic [4:0] rand_a,
	input  logic [5:0] rand_b,
	input  logic [4:0] rand_c,
	output off_set_t   cur
);

	localparam logic signed [7:0] LIM = 8'(OFFSET_LIMIT);

	off_set_t cur_q;
	off_set_t cur_d;
	off_set_t stepped;
	off_set_t rnd;
	off_set_t clamped;
	logic signed [6:0] rb_raw;
	logic signed [7:0] rb_mapped;

	// Move one step toward the target.
	function automatic off_t step_to(input off_t v, input off_t t);
		off_t r;
		if (v < t) begin
			r = v + 7'sd1;
		end else if (v > t) begin
			r = v - 7'sd1;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Random offsets; b is pushed away from small magnitudes.
	always_comb begin
		rb_raw = $signed({1'b0, rand_b}) - 7'sd32;
		if (rb_raw < 7'sd0 && rb_raw > -7'sd16) begin
			rb_mapped = -8'sd32;
		end else if (rb_raw >= 7'sd0 && rb_raw < 7'sd16) begin
			rb_mapped = 8'sd32;
		end else begin
			rb_mapped = {rb_raw[6], rb_raw};
		end
		rnd.a = clamp_off($signed({3'b000, rand_a}) - 8'sd6, LIM);
		rnd.b = clamp_off(rb_mapped, LIM);
		rnd.c = clamp_off($signed({3'b000, rand_c}) - 8'sd6, LIM);
	end

	// Step and clamp of the held offsets.
	always_comb begin
		stepped.a = step_to(cur_q.a, base.a);
		stepped.b = step_to(cur_q.b, base.b);
		stepped.c = step_to(cur_q.c, base.c);
		clamped.a = clamp_off({cur_q.a[6], cur_q.a}, LIM);
		clamped.b = clamp_off({cur_q.b[6], cur_q.b}, LIM);
		clamped.c = clamp_off({cur_q.c[6], cur_q.c}, LIM);
	end

	// Next offsets: resync after a write, otherwise the frame-start update.
	always_comb begin
		cur_d = cur_q;
		if (resync) begin
			cur_d = mode.smooth ? clamped : base;
		end else if (frame_go) begin
			if (!mode.smooth) begin
				cur_d = base;
			end else if (!beat) begin
				cur_d = stepped;
			end else begin
				cur_d = mode.randomize ? rnd : beat_off;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= OFF_SET_RST;
		end else begin
			cur_q <= cur_d;
		end
	end

	assign cur = cur_q;

endmodule

// ===== rtl/dcf_pixel_fade.sv =====
// Pixel datapath: dominant channel search, offset permutation and saturating adds.
// Depends on dcf_pkg; purely combinational, sits between the pipeline registers.
`timescale 1ns / 1ps

module dcf_pixel_fade import dcf_pkg::*; (
	input  logic       enable,
	input  logic [7:0] p0,
	input  logic [7:0] p1,
	input  logic [7:0] p2,
	input  off_set_t   offs,
	output out_item_t  result
);

	off_t d0;
	off_t d1;
	off_t d2;

	// Add a signed offset to a byte, saturating to 0..255.
	function automatic logic [7:0] sat_add(input logic [7:0] px, input off_t d);
		logic signed [9:0] s;
		logic [7:0] r;
		s = $signed({2'b00, px}) + {{3{d[6]}}, d};
		if (s <= 10'sd0) begin
			r = 8'd0;
		end else if (s >= 10'sd255) begin
			r = 8'd255;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

	// Choose the permutation from the strictly largest byte.
	always_comb begin
		if (p1 > p2 && p1 > p0) begin
			d0 = offs.c; d1 = offs.b; d2 = offs.a;
		end else if (p0 > p1 && p0 > p2) begin
			d0 = offs.b; d1 = offs.a; d2 = offs.c;
		end else if (p2 > p0 && p2 > p1) begin
			d0 = offs.a; d1 = offs.c; d2 = offs.b;
		end else begin
			d0 = offs.c; d1 = offs.c; d2 = offs.c;
		end
	end

	// Disabled pixels pass through unchanged.
	always_comb begin
		if (enable) begin
			result.chan0_out = sat_add(p0, d0);
			result.chan1_out = sat_add(p1, d1);
			result.chan2_out = sat_add(p2, d2);
		end else begin
			result.chan0_out = p0;
			result.chan1_out = p1;
			result.chan2_out = p2;
		end
	end

endmodule

// ===== rtl/dominant_channel_color_fade.sv =====
// Dominant-channel colour fade: one item per cycle unless the output stalls; a pixel is
// faded into the result register, a frame-start item gives no result and, when enabled,
// updates the offsets on leaving the input register. The two registers part the channels,
// so a new item can be taken while a result waits. Asynchronous active-low reset empties
// both registers and loads mode enable, base, beat and current offsets 8, -8, -8.
`timescale 1ns / 1ps
`include "dominant_channel_color_fade_macros.svh"

module dominant_channel_color_fade import dcf_pkg::*; #(
	parameter int OFFSET_LIMIT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data
);

	mode_t     mode;
	off_set_t  base;
	off_set_t  beat_off;
	off_set_t  offs;
	logic      resync;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t item_s2;
	logic      valid_s2;
	out_item_t fade_res;
	logic      adv_s2;
	logic      done_s1;
	logic      frame_go;

	assign cfg_ready = 1'b1;

	dcf_cfg_regs #(
		.OFFSET_LIMIT(OFFSET_LIMIT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.mode     (mode),
		.base     (base),
		.beat_off (beat_off),
		.resync   (resync)
	);

	// The result register can take a new item when empty or being emptied.
	assign adv_s2   = !valid_s2 || out_ready;
	// A frame item always leaves the input register; a pixel needs room downstream.
	assign done_s1  = valid_s1 && (item_s1.func == FUNC_FRAME || adv_s2);
	assign in_ready = !valid_s1 || done_s1;
	assign frame_go = done_s1 && item_s1.func == FUNC_FRAME && mode.enable;

	dcf_offsets #(
		.OFFSET_LIMIT(OFFSET_LIMIT)
	) u_offs (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode),
		.base    (base),
		.beat_off(beat_off),
		.resync  (resync),
		.frame_go(frame_go),
		.beat    (item_s1.beat),
		.rand_a  (item_s1.rand_a),
		.rand_b  (item_s1.rand_b),
		.rand_c  (item_s1.rand_c),
		.cur     (offs)
	);

	dcf_pixel_fade u_fade (
		.enable(mode.enable),
		.p0    (item_s1.chan0_in),
		.p1    (item_s1.chan1_in),
		.p2    (item_s1.chan2_in),
		.offs  (offs),
		.result(fade_res)
	);

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Result register valid: loaded only by pixel items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1 && item_s1.func == FUNC_PIXEL;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1 && item_s1.func == FUNC_PIXEL) begin
			item_s2 <= fade_res;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// A result appears only after a pixel item left the input register.
	`DCF_ASSERT_SAME(a_result_from_pixel, clk, arst_n, $rose(valid_s2),
		$past(valid_s1 && item_s1.func == FUNC_PIXEL))
	// A frame start while disabled leaves the offsets alone.
	`DCF_ASSERT_NEXT(a_disabled_frame_holds, clk, arst_n,
		done_s1 && item_s1.func == FUNC_FRAME && !mode.enable && !resync, $stable(offs))
	// Without smoothing a frame start loads the base offsets.
	`DCF_ASSERT_NEXT(a_frame_loads_base, clk, arst_n,
		frame_go && !mode.smooth && !resync, offs == $past(base))

endmodule

// ===== tb/dominant_channel_color_fade_test.sv =====
// Self-checking testbench for the dominant-channel colour fade block.
// A scoreboard class predicts every pixel result from typed items; it depends only on dcf_pkg
// and the RTL of dominant_channel_color_fade.
`timescale 1ns / 1ps

module dominant_channel_color_fade_test;
	import dcf_pkg::*;

	localparam int FADE_LIMIT = 32;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 4;
	localparam int END_CYCLES = 16;
	localparam int NUM_SETTINGS = 10;
	localparam int ITEMS_PER_SETTING = 125;
	localparam int HOLD_SETTING = 3;
	localparam logic [2:0] REG_NONE = 3'd7;

	// Ways in which the receiver takes results.
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_DENSE} rx_pattern_t;

	// Keeps its own copy of the registers and live offsets, and the faded pixels still owed.
	class fade_scoreboard;
		mode_t     mode;
		off_t      rest_ofs[3];
		off_t      beat_ofs[3];
		off_t      live_ofs[3];
		out_item_t faded_q[$];
		int        errors;
		int        pixels;
		int        frames;
		int        beats;

		function new();
			mode = MODE_RST;
			rest_ofs = '{OFF_RST_POS, OFF_RST_NEG, OFF_RST_NEG};
			beat_ofs = '{OFF_RST_POS, OFF_RST_NEG, OFF_RST_NEG};
			live_ofs = '{OFF_RST_POS, OFF_RST_NEG, OFF_RST_NEG};
			errors = 0;
			pixels = 0;
			frames = 0;
			beats = 0;
		endfunction

		function int limit_ofs(int v);
			if (v < -FADE_LIMIT) begin
				return -FADE_LIMIT;
			end
			if (v > FADE_LIMIT) begin
				return FADE_LIMIT;
			end
			return v;
		endfunction

		function logic [7:0] fade_byte(logic [7:0] p, int d);
			int v;
			v = int'(p) + d;
			if (v <= 0) begin
				return 8'd0;
			end
			if (v >= 255) begin
				return 8'd255;
			end
			return v[7:0];
		endfunction

		function int pending();
			return faded_q.size();
		endfunction

		// A register write; afterwards the live offsets follow the base set unless fading.
		function void write_reg(logic [2:0] idx, logic [6:0] data);
			int v;
			v = $signed(data);
			case (idx)
				REG_MODE: begin
					mode = mode_t'(data[2:0]);
				end
				REG_BASE_A, REG_BASE_B, REG_BASE_C: begin
					rest_ofs[int'(idx) - int'(REG_BASE_A)] = off_t'(limit_ofs(v));
				end
				REG_BEAT_A, REG_BEAT_B, REG_BEAT_C: begin
					beat_ofs[int'(idx) - int'(REG_BEAT_A)] = off_t'(limit_ofs(v));
				end
				default: begin
					return;
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				if (!mode.smooth) begin
					live_ofs[k] = rest_ofs[k];
				end else begin
					live_ofs[k] = off_t'(limit_ofs(live_ofs[k]));
				end
			end
		endfunction

		// Frame start: nothing when disabled, else reload, or fade one step and apply any beat.
		function void start_frame(in_item_t it);
			int ra;
			int rb;
			int rc;
			frames++;
			if (!mode.enable) begin
				return;
			end
			if (!mode.smooth) begin
				live_ofs = rest_ofs;
				return;
			end
			for (int k = 0; k < 3; k++) begin
				if (live_ofs[k] < rest_ofs[k]) begin
					live_ofs[k] = off_t'(live_ofs[k] + 1);
				end else if (live_ofs[k] > rest_ofs[k]) begin
					live_ofs[k] = off_t'(live_ofs[k] - 1);
				end
			end
			if (!it.beat) begin
				return;
			end
			beats++;
			if (mode.randomize) begin
				ra = int'(it.rand_a) - 6;
				rb = int'(it.rand_b) - 32;
				rc = int'(it.rand_c) - 6;
				// Small magnitudes of b are pushed out to the full swing.
				if (rb < 0 && rb > -16) begin
					rb = -32;
				end
				if (rb >= 0 && rb < 16) begin
					rb = 32;
				end
				live_ofs[0] = off_t'(limit_ofs(ra));
				live_ofs[1] = off_t'(limit_ofs(rb));
				live_ofs[2] = off_t'(limit_ofs(rc));
			end else begin
				live_ofs = beat_ofs;
			end
		endfunction

		// Pixel: the strictly dominant channel picks the order of the offsets.
		function out_item_t fade_pixel(in_item_t it);
			out_item_t r;
			int a;
			int b;
			int c;
			int d0;
			int d1;
			int d2;
			logic [7:0] p0;
			logic [7:0] p1;
			logic [7:0] p2;
			p0 = it.chan0_in;
			p1 = it.chan1_in;
			p2 = it.chan2_in;
			if (!mode.enable) begin
				r.chan0_out = p0;
				r.chan1_out = p1;
				r.chan2_out = p2;
				return r;
			end
			a = live_ofs[0];
			b = live_ofs[1];
			c = live_ofs[2];
			if (p1 > p2 && p1 > p0) begin
				d0 = c; d1 = b; d2 = a;
			end else if (p0 > p1 && p0 > p2) begin
				d0 = b; d1 = a; d2 = c;
			end else if (p2 > p0 && p2 > p1) begin
				d0 = a; d1 = c; d2 = b;
			end else begin
				d0 = c; d1 = c; d2 = c;
			end
			r.chan0_out = fade_byte(p0, d0);
			r.chan1_out = fade_byte(p1, d1);
			r.chan2_out = fade_byte(p2, d2);
			return r;
		endfunction

		function void note_input(in_item_t it);
			if (it.func == FUNC_FRAME) begin
				start_frame(it);
			end else begin
				faded_q.push_back(fade_pixel(it));
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (faded_q.size() == 0) begin
				$error("result %h arrived with no pixel outstanding", got);
				errors++;
				return;
			end
			want = faded_q.pop_front();
			pixels++;
			if (got.chan0_out !== want.chan0_out) begin
				$error("chan0_out: expected %0d, actual %0d", want.chan0_out, got.chan0_out);
				errors++;
			end
			if (got.chan1_out !== want.chan1_out) begin
				$error("chan1_out: expected %0d, actual %0d", want.chan1_out, got.chan1_out);
				errors++;
			end
			if (got.chan2_out !== want.chan2_out) begin
				$error("chan2_out: expected %0d, actual %0d", want.chan2_out, got.chan2_out);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_item;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [6:0] cfg_data;

	fade_scoreboard sb = new();

	int          burst_left = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_taken = 1'b0;
	int          hold_left = 0;
	int          rx_cycle = 0;
	rx_pattern_t rx_pattern = RX_OPEN;
	bit          rst_done = 1'b0;
	int          idle_cycles = 0;
	int          cfg_writes = 0;

	dominant_channel_color_fade #(
		.OFFSET_LIMIT(FADE_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: checks each accepted result, then picks its next ready level.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_result(out_item);
		end
		rx_cycle++;
		if (rx_cycle % 128 == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
		end
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_pattern)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= (rx_cycle % 4 == 0);
				default:   out_ready <= (rx_cycle % 4 != 0);
			endcase
		end
	end

	// Watchdog: ends the run when no channel has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else if (rst_done) begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one item, after a random gap when a new burst starts, and waits for it to go in.
	task automatic send_item(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	// Holds the input back until every owed pixel is out and a trailing frame start is done.
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller lowers cfg_valid after the last of a batch.
	task automatic put_reg(logic [2:0] idx, logic [6:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_writes++;
	endtask

	function automatic in_item_t pixel_item(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
		in_item_t it;
		it = '0;
		it.func = FUNC_PIXEL;
		it.chan0_in = c0;
		it.chan1_in = c1;
		it.chan2_in = c2;
		return it;
	endfunction

	function automatic in_item_t frame_item(logic b, logic [4:0] ra, logic [5:0] rb,
		logic [4:0] rc);
		in_item_t it;
		it = '0;
		it.func = FUNC_FRAME;
		it.beat = b;
		it.rand_a = ra;
		it.rand_b = rb;
		it.rand_c = rc;
		return it;
	endfunction

	// Offset register data: mostly in range, often at the limits, sometimes beyond them.
	function automatic logic [6:0] random_ofs_data();
		int v;
		case ($urandom_range(0, 9))
			0: v = FADE_LIMIT;
			1: v = -FADE_LIMIT;
			2, 3: v = int'($urandom_range(0, 127)) - 64;
			default: v = int'($urandom_range(0, 2 * FADE_LIMIT)) - FADE_LIMIT;
		endcase
		return v[6:0];
	endfunction

	// Bytes lean towards both ends so that the saturating adds are exercised.
	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 40));
			1: return 8'($urandom_range(215, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Every field is random; pixels get shaped bytes and a share of ties.
	function automatic in_item_t random_item();
		in_item_t it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.func = ($urandom_range(0, 99) < 15) ? FUNC_FRAME : FUNC_PIXEL;
		if (it.func == FUNC_PIXEL) begin
			it.chan0_in = random_byte();
			it.chan1_in = random_byte();
			it.chan2_in = random_byte();
			case ($urandom_range(0, 9))
				0: it.chan1_in = it.chan0_in;
				1: it.chan2_in = it.chan1_in;
				2: it.chan2_in = it.chan0_in;
				3: begin
					it.chan1_in = it.chan0_in;
					it.chan2_in = it.chan0_in;
				end
				default: ;
			endcase
		end
		return it;
	endfunction

	// Loads one register setting; the first two are the extremes of the offsets.
	task automatic configure_setting(int setting);
		logic [6:0] vals[7];
		logic [6:0] mode_data;
		bit mode_last;
		wait_drained();
		mode_data = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 4) != 0) begin
			mode_data[0] = 1'b1;
		end
		for (int k = 1; k < 7; k++) begin
			vals[k] = random_ofs_data();
		end
		if (setting == 0) begin
			mode_data[2:0] = 3'b111;
			for (int k = 1; k < 7; k++) vals[k] = 7'd32;
		end else if (setting == 1) begin
			mode_data[2:0] = 3'b101;
			for (int k = 1; k < 7; k++) vals[k] = 7'h60;
		end
		mode_last = 1'($urandom_range(0, 1));
		if (!mode_last) begin
			put_reg(REG_MODE, mode_data);
		end
		for (int k = 1; k < 7; k++) begin
			if (setting < 2 || $urandom_range(0, 4) != 0) begin
				put_reg(cfg_reg_t'(k), vals[k]);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			put_reg(REG_NONE, 7'($urandom_range(0, 127)));
		end
		if (mode_last) begin
			put_reg(REG_MODE, mode_data);
		end
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed items, then random items under a series of register settings.
	initial begin
		in_item_t probe;
		in_valid <= 1'b0;
		in_item <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		rst_done = 1'b1;
		@(posedge clk);

		// Reset settings: enabled, no fading, offsets 8, -8, -8; ties and each dominant channel.
		send_item(pixel_item(8'd0, 8'd0, 8'd0));
		send_item(pixel_item(8'd255, 8'd255, 8'd255));
		send_item(pixel_item(8'd10, 8'd200, 8'd5));
		send_item(pixel_item(8'd250, 8'd3, 8'd4));
		send_item(pixel_item(8'd1, 8'd2, 8'd253));
		send_item(pixel_item(8'd100, 8'd100, 8'd50));
		send_item(pixel_item(8'd7, 8'd90, 8'd90));
		send_item(frame_item(1'b1, 5'd31, 6'd63, 5'd31));
		// Beat and draws on a pixel item must have no effect.
		probe = pixel_item(8'd255, 8'd0, 8'd128);
		probe.beat = 1'b1;
		probe.rand_a = '1;
		probe.rand_b = '1;
		probe.rand_c = '1;
		send_item(probe);

		// Out-of-range offsets are clamped and an unknown index is dropped; then fading on.
		wait_drained();
		put_reg(REG_BASE_A, 7'd32);
		put_reg(REG_BASE_B, 7'h40);
		put_reg(REG_BASE_C, 7'd63);
		put_reg(REG_BEAT_A, 7'h5F);
		put_reg(REG_BEAT_B, 7'd33);
		put_reg(REG_BEAT_C, 7'd0);
		put_reg(REG_NONE, 7'h7F);
		put_reg(REG_MODE, 7'h7D);
		put_reg(REG_BASE_A, 7'h60);
		cfg_valid <= 1'b0;
		send_item(frame_item(1'b0, '0, '0, '0));
		send_item(pixel_item(8'd255, 8'd0, 8'd0));
		send_item(frame_item(1'b1, '0, '0, '0));
		send_item(pixel_item(8'd0, 8'd255, 8'd0));
		send_item(pixel_item(8'd128, 8'd128, 8'd128));

		// Randomised beats, with the draws for b either side of the dead zone.
		wait_drained();
		put_reg(REG_MODE, 7'd7);
		cfg_valid <= 1'b0;
		send_item(frame_item(1'b1, 5'd0, 6'd17, 5'd31));
		send_item(pixel_item(8'd3, 8'd250, 8'd100));
		send_item(frame_item(1'b1, 5'd31, 6'd32, 5'd0));
		send_item(pixel_item(8'd100, 8'd3, 8'd250));
		send_item(frame_item(1'b1, 5'd6, 6'd63, 5'd6));
		send_item(frame_item(1'b1, 5'd6, 6'd0, 5'd6));
		send_item(pixel_item(8'd200, 8'd100, 8'd0));
		send_item(frame_item(1'b0, 5'd31, 6'd31, 5'd31));

		// Disabled: pixels pass through and frame starts leave the offsets alone.
		wait_drained();
		put_reg(REG_MODE, 7'd6);
		cfg_valid <= 1'b0;
		send_item(pixel_item(8'd1, 8'd2, 8'd3));
		send_item(frame_item(1'b1, 5'd31, 6'd47, 5'd31));
		send_item(pixel_item(8'd255, 8'd254, 8'd0));

		// Randomise without fading: a frame start just reloads the base set.
		wait_drained();
		put_reg(REG_MODE, 7'd3);
		cfg_valid <= 1'b0;
		send_item(frame_item(1'b1, 5'd31, 6'd47, 5'd31));
		send_item(pixel_item(8'd0, 8'd0, 8'd255));

		// Random part; one setting runs against a long receiver hold-off.
		for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
			configure_setting(setting);
			quiet = (setting == HOLD_SETTING) || ($urandom_range(0, 3) == 0);
			if (setting == HOLD_SETTING) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				send_item(random_item());
			end
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		$display("Checked %0d faded pixels and %0d frame starts, %0d of them beats,",
			sb.pixels, sb.frames, sb.beats);
		$display("across %0d register settings and %0d register writes.",
			NUM_SETTINGS + 4, cfg_writes);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
